>>> hw/rtl/segment_rectangle_overlap_test_assert.svh
// ----------------------------------------------------------------------------
// segment_rectangle_overlap_test assertion macros
// shared property forms for the overlap test
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RECTANGLE_OVERLAP_TEST_ASSERT_SVH
`define SEGMENT_RECTANGLE_OVERLAP_TEST_ASSERT_SVH

// condition holds at every edge out of reset
`define SROT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("srot assertion failed");

// antecedent implies consequent in the next cycle
`define SROT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srot assertion failed");

// checked during reset as well
`define SROT_ASSERT_NORST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("srot assertion failed");

`endif

>>> hw/rtl/srot_pkg.sv
// ----------------------------------------------------------------------------
// srot_pkg
// shared constants and types of the segment/rectangle overlap test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srot_pkg;

   localparam int COORD_BITS_DEF = 24;

   // per-item flags handed from the geometry front end to the result stages
   typedef struct packed {
      logic empty;     // clipped x span is empty
      logic vertical;  // p1_x equals p2_x
   } seg_flags_type;

   // bits of a field list rounded up to whole bytes
   function automatic int byte_pad(input int bits);
      byte_pad = ((bits + 7) / 8) * 8;
   endfunction

endpackage

>>> hw/rtl/srot_front.sv
// ----------------------------------------------------------------------------
// srot_front
// two-stage geometry front end: x clipping, offsets and magnitudes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srot_front #(
   parameter int COORD_BITS = srot_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] rect_left,
   input  logic signed [COORD_BITS-1:0] rect_top,
   input  logic        [COORD_BITS-2:0] rect_width,
   input  logic        [COORD_BITS-2:0] rect_height,
   input  logic signed [COORD_BITS-1:0] p1_x,
   input  logic signed [COORD_BITS-1:0] p1_y,
   input  logic signed [COORD_BITS-1:0] p2_x,
   input  logic signed [COORD_BITS-1:0] p2_y,
   output logic                         out_valid,
   output logic        [COORD_BITS-1:0] a_lo,
   output logic        [COORD_BITS-1:0] a_hi,
   output logic        [COORD_BITS-1:0] b_mag,
   output logic        [COORD_BITS-1:0] d_mag,
   output logic                         neg_lo,
   output logic                         neg_hi,
   output srot_pkg::seg_flags_type      flags,
   output logic signed [COORD_BITS-1:0] y1_out,
   output logic signed [COORD_BITS-1:0] y2_out,
   output logic signed [COORD_BITS-1:0] top_out,
   output logic signed [COORD_BITS:0]   bot_out
);

   localparam int CB = COORD_BITS;

   // stage 1
   logic                 v1_ff;
   logic signed [CB-1:0] left_ff, top1_ff, minx_ff, maxx_ff, x1_ff, y1a_ff, y2a_ff;
   logic signed [CB:0]   rxhi_ff, ybot1_ff, dx_ff, dy_ff;
   logic signed [CB:0]   rxhi_in, ybot_in, dx_in, dy_in;

   assign rxhi_in = $signed({rect_left[CB-1], rect_left}) + $signed({2'b00, rect_width});
   assign ybot_in = $signed({rect_top[CB-1], rect_top}) + $signed({2'b00, rect_height});
   assign dx_in   = $signed({p2_x[CB-1], p2_x}) - $signed({p1_x[CB-1], p1_x});
   assign dy_in   = $signed({p2_y[CB-1], p2_y}) - $signed({p1_y[CB-1], p1_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         left_ff  <= rect_left;
         top1_ff  <= rect_top;
         rxhi_ff  <= rxhi_in;
         ybot1_ff <= ybot_in;
         minx_ff  <= (p1_x < p2_x) ? p1_x : p2_x;
         maxx_ff  <= (p1_x < p2_x) ? p2_x : p1_x;
         x1_ff    <= p1_x;
         y1a_ff   <= p1_y;
         y2a_ff   <= p2_y;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
      end
   end

   // stage 2
   logic signed [CB-1:0] lox;
   logic signed [CB:0]   hix, dxn, dyn;
   logic signed [CB+1:0] off_lo, off_hi, off_lo_n, off_hi_n;
   logic                 v2_ff;

   assign lox      = (minx_ff < left_ff) ? left_ff : minx_ff;
   assign hix      = ($signed({maxx_ff[CB-1], maxx_ff}) > rxhi_ff)
                     ? rxhi_ff : $signed({maxx_ff[CB-1], maxx_ff});
   assign off_lo   = $signed({{2{lox[CB-1]}}, lox}) - $signed({{2{x1_ff[CB-1]}}, x1_ff});
   assign off_hi   = $signed({hix[CB], hix}) - $signed({{2{x1_ff[CB-1]}}, x1_ff});
   assign off_lo_n = -off_lo;
   assign off_hi_n = -off_hi;
   assign dxn      = -dx_ff;
   assign dyn      = -dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_lo           <= off_lo[CB+1] ? off_lo_n[CB-1:0] : off_lo[CB-1:0];
         a_hi           <= off_hi[CB+1] ? off_hi_n[CB-1:0] : off_hi[CB-1:0];
         b_mag          <= dy_ff[CB] ? dyn[CB-1:0] : dy_ff[CB-1:0];
         d_mag          <= dx_ff[CB] ? dxn[CB-1:0] : dx_ff[CB-1:0];
         neg_lo         <= off_lo[CB+1] ^ dy_ff[CB] ^ dx_ff[CB];
         neg_hi         <= off_hi[CB+1] ^ dy_ff[CB] ^ dx_ff[CB];
         flags.empty    <= $signed({lox[CB-1], lox}) > hix;
         flags.vertical <= (dx_ff == '0);
         y1_out         <= y1a_ff;
         y2_out         <= y2a_ff;
         top_out        <= top1_ff;
         bot_out        <= ybot1_ff;
      end
   end

   assign out_valid = v2_ff;

endmodule

>>> hw/rtl/srot_mul_div.sv
// ----------------------------------------------------------------------------
// srot_mul_div
// pipelined floor(a * b / d): one multiply stage, then one quotient bit
// per stage of a restoring divider; a tag rides along
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srot_mul_div #(
   parameter int COORD_BITS = srot_pkg::COORD_BITS_DEF,
   parameter int TAG_W      = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [COORD_BITS-1:0] a,
   input  logic [COORD_BITS-1:0] b,
   input  logic [COORD_BITS-1:0] d,
   input  logic [TAG_W-1:0]      tag_in,
   output logic                  out_valid,
   output logic [COORD_BITS-1:0] q,
   output logic [TAG_W-1:0]      tag_out
);

   localparam int CB = COORD_BITS;

   logic          v_ff   [0:CB];
   logic [CB-1:0] rem_ff [0:CB];
   logic [CB-1:0] low_ff [0:CB];
   logic [CB-1:0] quo_ff [0:CB];
   logic [CB-1:0] div_ff [0:CB];
   logic [TAG_W-1:0] tag_ff [0:CB];
   logic [2*CB-1:0]  prod;

   assign prod = a * b;

   // multiply stage: a <= d keeps the high half below d
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= prod[2*CB-1:CB];
         low_ff[0] <= prod[CB-1:0];
         quo_ff[0] <= '0;
         div_ff[0] <= d;
         tag_ff[0] <= tag_in;
      end
   end

   for (genvar k = 0; k < CB; k++) begin : g_step
      logic [CB:0] trial, diff;
      logic        ge;

      assign trial = {rem_ff[k], low_ff[k][CB-1]};
      assign ge    = trial >= {1'b0, div_ff[k]};
      assign diff  = trial - {1'b0, div_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? diff[CB-1:0] : trial[CB-1:0];
            low_ff[k+1] <= {low_ff[k][CB-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][CB-2:0], ge};
            div_ff[k+1] <= div_ff[k];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign out_valid = v_ff[CB];
   assign q         = quo_ff[CB];
   assign tag_out   = tag_ff[CB];

endmodule

>>> hw/rtl/srot_back.sv
// ----------------------------------------------------------------------------
// srot_back
// two-stage back end: y at the clipped x ends, ordering, y clipping, result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srot_back #(
   parameter int COORD_BITS = srot_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic        [COORD_BITS-1:0] q_lo,
   input  logic        [COORD_BITS-1:0] q_hi,
   input  logic                         neg_lo,
   input  logic                         neg_hi,
   input  srot_pkg::seg_flags_type      flags,
   input  logic signed [COORD_BITS-1:0] y1,
   input  logic signed [COORD_BITS-1:0] y2,
   input  logic signed [COORD_BITS-1:0] top,
   input  logic signed [COORD_BITS:0]   bot,
   output logic                         out_valid,
   output logic                         visible
);

   localparam int CB = COORD_BITS;

   logic signed [CB+1:0] y1e, y2e, qlo_e, qhi_e, ylo_in, yhi_in;
   logic signed [CB+1:0] ylo_ff, yhi_ff, top_ff, bot_ff;
   logic                 empty_ff, v1_ff, v2_ff;

   assign y1e    = $signed({{2{y1[CB-1]}}, y1});
   assign y2e    = $signed({{2{y2[CB-1]}}, y2});
   assign qlo_e  = $signed({2'b00, q_lo});
   assign qhi_e  = $signed({2'b00, q_hi});
   assign ylo_in = flags.vertical ? y1e : (neg_lo ? y1e - qlo_e : y1e + qlo_e);
   assign yhi_in = flags.vertical ? y2e : (neg_hi ? y1e - qhi_e : y1e + qhi_e);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ylo_ff   <= ylo_in;
         yhi_ff   <= yhi_in;
         top_ff   <= $signed({{2{top[CB-1]}}, top});
         bot_ff   <= $signed({bot[CB], bot});
         empty_ff <= flags.empty;
      end
   end

   logic signed [CB+1:0] mn, mx, mn_c, mx_c;

   assign mn   = (ylo_ff > yhi_ff) ? yhi_ff : ylo_ff;
   assign mx   = (ylo_ff > yhi_ff) ? ylo_ff : yhi_ff;
   assign mn_c = (mn < top_ff) ? top_ff : mn;
   assign mx_c = (mx > bot_ff) ? bot_ff : mx;

   always_ff @(posedge clock) begin
      if (en) begin
         visible <= !empty_ff && !(mn_c > mx_c);
      end
   end

   assign out_valid = v2_ff;

endmodule

>>> hw/rtl/segment_rectangle_overlap_test.sv
// ----------------------------------------------------------------------------
// segment_rectangle_overlap_test
// reports whether a line segment touches an axis-aligned rectangle
// ----------------------------------------------------------------------------
//  channel  dir  beat contents (lowest bits first)
//  req_     in   rect_left, rect_top, rect_width, rect_height, p1_x, p1_y,
//                p2_x, p2_y
//  rsp_     out  visible
//
//  one beat in and one beat out per cycle while the output is not stalled;
//  the restoring divider yields one quotient bit per stage
//  reset clears the stage valid bits only
//  the whole pipeline holds while rsp_tvalid is high and rsp_tready low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_rectangle_overlap_test_assert.svh"

module segment_rectangle_overlap_test #(
   parameter int COORD_BITS = srot_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // rect_left, rect_top, rect_width, rect_height, p1_x, p1_y, p2_x, p2_y
   input  logic [srot_pkg::byte_pad(8*COORD_BITS-2)-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // visible
   output logic [7:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready
);

   localparam int CB    = COORD_BITS;
   localparam int TAG_W = 1 + $bits(srot_pkg::seg_flags_type) + 4*CB + 1;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic signed [CB-1:0] f_left, f_top, f_p1x, f_p1y, f_p2x, f_p2y;
   logic        [CB-2:0] f_w, f_h;

   assign f_left = $signed(req_tdata[CB-1:0]);
   assign f_top  = $signed(req_tdata[2*CB-1:CB]);
   assign f_w    = req_tdata[3*CB-2:2*CB];
   assign f_h    = req_tdata[4*CB-3:3*CB-1];
   assign f_p1x  = $signed(req_tdata[5*CB-3:4*CB-2]);
   assign f_p1y  = $signed(req_tdata[6*CB-3:5*CB-2]);
   assign f_p2x  = $signed(req_tdata[7*CB-3:6*CB-2]);
   assign f_p2y  = $signed(req_tdata[8*CB-3:7*CB-2]);

   logic                    fr_valid, fr_neg_lo, fr_neg_hi;
   logic [CB-1:0]           fr_a_lo, fr_a_hi, fr_b, fr_d;
   srot_pkg::seg_flags_type fr_flags;
   logic signed [CB-1:0]    fr_y1, fr_y2, fr_top;
   logic signed [CB:0]      fr_bot;

   srot_front #(.COORD_BITS(CB)) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_tvalid),
      .rect_left  (f_left),
      .rect_top   (f_top),
      .rect_width (f_w),
      .rect_height(f_h),
      .p1_x       (f_p1x),
      .p1_y       (f_p1y),
      .p2_x       (f_p2x),
      .p2_y       (f_p2y),
      .out_valid  (fr_valid),
      .a_lo       (fr_a_lo),
      .a_hi       (fr_a_hi),
      .b_mag      (fr_b),
      .d_mag      (fr_d),
      .neg_lo     (fr_neg_lo),
      .neg_hi     (fr_neg_hi),
      .flags      (fr_flags),
      .y1_out     (fr_y1),
      .y2_out     (fr_y2),
      .top_out    (fr_top),
      .bot_out    (fr_bot)
   );

   logic [TAG_W-1:0] lo_tag_in, lo_tag_out;
   logic             lo_valid, hi_valid, hi_tag_out;
   logic [CB-1:0]    q_lo, q_hi;

   assign lo_tag_in = {fr_neg_lo, fr_flags, fr_y1, fr_y2, fr_top, fr_bot};

   srot_mul_div #(.COORD_BITS(CB), .TAG_W(TAG_W)) u_div_lo (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (fr_valid),
      .a        (fr_a_lo),
      .b        (fr_b),
      .d        (fr_d),
      .tag_in   (lo_tag_in),
      .out_valid(lo_valid),
      .q        (q_lo),
      .tag_out  (lo_tag_out)
   );

   srot_mul_div #(.COORD_BITS(CB), .TAG_W(1)) u_div_hi (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (fr_valid),
      .a        (fr_a_hi),
      .b        (fr_b),
      .d        (fr_d),
      .tag_in   (fr_neg_hi),
      .out_valid(hi_valid),
      .q        (q_hi),
      .tag_out  (hi_tag_out)
   );

   logic                    bk_neg_lo;
   srot_pkg::seg_flags_type bk_flags;
   logic signed [CB-1:0]    bk_y1, bk_y2, bk_top;
   logic signed [CB:0]      bk_bot;
   logic                    visible;

   assign {bk_neg_lo, bk_flags, bk_y1, bk_y2, bk_top, bk_bot} = lo_tag_out;

   srot_back #(.COORD_BITS(CB)) u_back (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (lo_valid),
      .q_lo     (q_lo),
      .q_hi     (q_hi),
      .neg_lo   (bk_neg_lo),
      .neg_hi   (hi_tag_out),
      .flags    (bk_flags),
      .y1       (bk_y1),
      .y2       (bk_y2),
      .top      (bk_top),
      .bot      (bk_bot),
      .out_valid(rsp_tvalid),
      .visible  (visible)
   );

   assign rsp_tdata = {7'b0, visible};

   // both divider lanes carry the same beats
   `SROT_ASSERT_ALWAYS(a_lanes_aligned, clock, reset, lo_valid == hi_valid)
   `SROT_ASSERT_ALWAYS(a_ready_from_stall, clock, reset, req_tready == (!rsp_tvalid || rsp_tready))
   `SROT_ASSERT_NORST(a_reset_empties, clock, reset, !rsp_tvalid)
   `SROT_ASSERT_NEXT(a_stall_freezes_lanes, clock, reset, !en, $stable(lo_valid) && $stable(q_lo))

endmodule

>>> dv/segment_rectangle_overlap_test_tb.sv
// ----------------------------------------------------------------------------
// segment_rectangle_overlap_test_tb
// drives segment/rectangle pairs through the overlap test and checks every
// visible bit against an exact integer predictor, in stream order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_rectangle_overlap_test_tb;

   localparam int CB = srot_pkg::COORD_BITS_DEF;
   localparam int DW = srot_pkg::byte_pad(8*CB-2);
   localparam int LATENCY = CB + 5;
   localparam int N_RANDOM = 600;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic signed [CB-1:0] left;
      logic signed [CB-1:0] top;
      logic [CB-2:0] width;
      logic [CB-2:0] height;
      logic signed [CB-1:0] x1;
      logic signed [CB-1:0] y1;
      logic signed [CB-1:0] x2;
      logic signed [CB-1:0] y2;
   } seg_rect_type;

   typedef struct {
      seg_rect_type item;
      int known;   // -1: predictor only, else the hand-read answer
   } stim_row_type;

   logic clock;
   logic reset;
   logic [DW-1:0] req_tdata;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready;

   bit expected_visible[$];
   int mismatches;
   int idle_cycles;
   bit stim_done;
   bit calm;        // no idling in the last part of the run
   bit hold_off;    // long receiver stall requested

   segment_rectangle_overlap_test u_top (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [39:0] y_on_line(logic signed [39:0] x,
         logic signed [39:0] x1, logic signed [39:0] y1,
         logic signed [39:0] dx, logic signed [39:0] dy);
      logic signed [79:0] num;
      logic signed [79:0] q;
      begin
         num = 80'(x - x1) * 80'(dy);
         q = num / 80'(dx);   // sv division truncates toward zero
         y_on_line = y1 + 40'(q);
      end
   endfunction

   function automatic bit touches(seg_rect_type s);
      logic signed [39:0] left, right, top, bottom, lo_x, hi_x, lo_y, hi_y, t, dx;
      begin
         left = s.left;
         right = left + $signed({1'b0, s.width});
         top = s.top;
         bottom = top + $signed({1'b0, s.height});
         lo_x = (s.x1 < s.x2) ? s.x1 : s.x2;
         hi_x = (s.x1 < s.x2) ? s.x2 : s.x1;
         if (hi_x > right) hi_x = right;
         if (lo_x < left) lo_x = left;
         if (lo_x > hi_x) return 1'b0;
         dx = 40'(s.x2) - 40'(s.x1);
         lo_y = s.y1;
         hi_y = s.y2;
         if (dx != 0) begin
            lo_y = y_on_line(lo_x, s.x1, s.y1, dx, 40'(s.y2) - 40'(s.y1));
            hi_y = y_on_line(hi_x, s.x1, s.y1, dx, 40'(s.y2) - 40'(s.y1));
         end
         if (lo_y > hi_y) begin
            t = lo_y; lo_y = hi_y; hi_y = t;
         end
         if (hi_y > bottom) hi_y = bottom;
         if (lo_y < top) lo_y = top;
         return lo_y <= hi_y;
      end
   endfunction

   function automatic logic [DW-1:0] pack_beat(seg_rect_type s);
      pack_beat = DW'({s.y2, s.x2, s.y1, s.x1, s.height, s.width, s.top, s.left});
   endfunction

   function automatic logic signed [CB-1:0] rand_coord(int span);
      if (span == 0) return CB'($urandom);
      return CB'($signed(32'($urandom_range(0, 2*span))) - span);
   endfunction

   // mostly segments near a modest rectangle, some full-range noise
   function automatic seg_rect_type rand_item();
      seg_rect_type s;
      int span;
      int mode;
      begin
         mode = $urandom_range(0, 9);
         span = (mode < 7) ? 4000 : 0;
         s.left = rand_coord(span);
         s.top = rand_coord(span);
         s.width = (mode < 7) ? (CB-1)'($urandom_range(0, 3000)) : (CB-1)'($urandom);
         s.height = (mode < 7) ? (CB-1)'($urandom_range(0, 3000)) : (CB-1)'($urandom);
         if (mode == 0) s.width = '0;
         if (mode == 1) s.height = '0;
         s.x1 = rand_coord(span);
         s.y1 = rand_coord(span);
         s.x2 = (mode == 2) ? s.x1 : rand_coord(span);
         s.y2 = rand_coord(span);
         return s;
      end
   endfunction

   task automatic send(seg_rect_type s);
      int gap;
      begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tdata <= pack_beat(s);
         req_tvalid <= 1'b1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         expected_visible.push_back(touches(s));
         @(negedge clock);
      end
   endtask

   // receiver stalls
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (150) @(negedge clock);
            hold_off = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result check
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_visible.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %h", rsp_tdata);
         end else begin
            want = expected_visible.pop_front();
            if (rsp_tdata[0] !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("visible mismatch: expected %0d, got %0d", want, rsp_tdata[0]);
            end
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (stim_done && expected_visible.size() == 0)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("segment_rectangle_overlap_test_tb: done, errors");
            $finish;
         end
      end
   end

   localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic [CB-2:0] WMAX = '1;

   stim_row_type directed[$] = '{
      // full-range rectangle, extreme diagonals
      '{'{CMIN, CMIN, WMAX, WMAX, CMIN, CMIN, CMAX, CMAX}, 1},
      '{'{CMIN, CMIN, WMAX, WMAX, CMAX, CMIN, CMIN, CMAX}, 0},
      // segment entirely right or left of rectangle
      '{'{0, 0, 100, 100, 200, 0, 300, 50}, 0},
      '{'{0, 0, 100, 100, -300, 0, -200, 50}, 0},
      // vertical segment crossing, below, and a point on the corner
      '{'{0, 0, 100, 100, 50, -50, 50, 150}, 1},
      '{'{0, 0, 100, 100, 50, 200, 50, 300}, 0},
      '{'{0, 0, 100, 100, 100, 100, 100, 100}, 1},
      // zero width and zero height rectangles
      '{'{10, 10, 0, 0, 0, 0, 20, 20}, 1},
      '{'{10, 10, 0, 0, 0, 0, 20, 21}, -1},
      '{'{10, 10, 0, 50, 0, 0, 20, 0}, 0},
      '{'{10, 10, 50, 0, 0, 0, 100, 40}, -1},
      // corner touch, near misses with truncation
      '{'{0, 0, 100, 100, 100, 100, 200, 200}, 1},
      '{'{0, 0, 100, 100, 101, 0, 200, 0}, 0},
      '{'{0, 0, 100, 100, -7, 103, 13, -9}, -1},
      '{'{0, 0, 100, 100, -300, 101, 3, 97}, -1},
      '{'{CMAX, CMAX, WMAX, WMAX, CMAX, CMAX, CMIN, CMIN}, 1},
      '{'{CMAX, CMIN, 0, WMAX, CMIN, CMAX, CMAX, CMIN}, -1},
      '{'{-5, -5, 10, 10, CMIN, CMAX, CMAX, CMIN}, -1}
   };

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      mismatches = 0;
      stim_done = 1'b0;
      calm = 1'b0;
      hold_off = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].known >= 0 && touches(directed[i].item) != directed[i].known[0]) begin
            mismatches++;
            if (mismatches <= 10) $display("directed row %0d: predictor disagrees", i);
         end
         send(directed[i].item);
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 100) hold_off = 1'b1;
         if (n == N_RANDOM - 100) calm = 1'b1;
         send(rand_item());
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;

      while (expected_visible.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0)
         $display("segment_rectangle_overlap_test_tb: done, clean");
      else
         $display("segment_rectangle_overlap_test_tb: done, errors");
      $finish;
   end

endmodule
